### hdl/bt_pkg.sv
// Shared types, constants and thinning tables for the binary thinning pass.
package bt_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int WID_W     = 11;                       // image_width register
    localparam int HGT_W     = 16;                       // image_height register
    localparam int WCL_W     = $clog2(MAX_WIDTH + 1);    // clamped width
    localparam int COL_W     = $clog2(MAX_WIDTH);        // column, pointer, fill
    localparam int MEM_DEPTH = MAX_WIDTH - 1;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int PEND_W    = $clog2(2 * MAX_WIDTH + 3);

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_METHOD = 2'd2;

    localparam logic       FUNC_PIXEL = 1'b0;
    localparam logic       FUNC_FLUSH = 1'b1;
    localparam logic [7:0] PIX_ON     = 8'd255;
    localparam logic [7:0] PIX_OFF    = 8'd0;
    localparam logic [7:0] FG_LEVEL   = 8'd128;

    // One slot of a line store: valid, raw binarized pixel, current result.
    typedef struct packed {
        logic valid;
        logic raw;
        logic s;
    } t_ent;

    // What a sub-iteration cell produces for its centre pixel.
    typedef struct packed {
        logic valid;
        logic raw;
        logic s;
        logic last;
    } t_res;

    // Tables indexed by neighbor code, entry 0 leftmost.
    localparam logic [0:255] TAB_ZS_A = {
        56'b11101100111101_00111111110111_01001111111111_11111101111111,
        56'b01110111111111_11111111111111_11111111111101_11111111111111,
        56'b01111111011101_11101011101111_11101111111111_11111011111111,
        56'b11111111111111_11111111110010_11101111111011_11111111111111,
        32'b00101110111111_11001011111111_1111
    };
    localparam logic [0:255] TAB_ZS_B = {
        56'b11101100111101_00111111110111_01001111111111_11111101111111,
        56'b01110100111111_11111111111111_11111111111101_11111111111111,
        56'b01111111011101_01101011101111_11111111111111_11111111111111,
        56'b11111111111111_11111111110010_11101111111111_11111111111111,
        32'b00111111111111_11001111110011_0111
    };
    localparam logic [0:255] TAB_GH_A = {
        56'b11111110110011_00111111111100_01001111111101_00010011111111,
        56'b01000100111111_11111111111111_11111111111111_11111101010101,
        56'b01111111010101_01111011101110_11101111111111_10111011111111,
        56'b11111111111111_11111111111111_11111111111111_11111111111111,
        32'b11111111111111_11111111111111_1111
    };
    localparam logic [0:255] TAB_GH_B = {
        56'b11111110111111_11111111111111_11111111111111_11111111111111,
        56'b01111111111111_11111111111111_11111111111111_11111111111111,
        56'b01111111011111_11110011001111_11111111111111_11111100001100,
        56'b11111111000011_11001111111000_11001111111111_11111111111111,
        32'b00001100111111_11000011110011_1111
    };

    function automatic logic thin_keep(input logic second, input logic method,
                                       input logic [7:0] code);
        logic k;
        case ({method, second})
            2'b00:   k = TAB_ZS_A[code];
            2'b01:   k = TAB_ZS_B[code];
            2'b10:   k = TAB_GH_A[code];
            2'b11:   k = TAB_GH_B[code];
            default: k = 1'b1;
        endcase
        return k;
    endfunction

endpackage

### hdl/bt_if.sv
// Handshake channel interfaces: pixel input, result output, register writes.
interface bt_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] pixel;
    modport source (output valid, func, pixel, input ready);
    modport sink   (input valid, func, pixel, output ready);
endinterface

interface bt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_out;
    logic       cleared;
    logic       last;
    logic       frame_changed;
    modport source (output valid, pixel_out, cleared, last, frame_changed, input ready);
    modport sink   (input valid, pixel_out, cleared, last, frame_changed, output ready);
endinterface

interface bt_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/binary_thinning_pass.sv
// Top level of the binary thinning pass: two chained sub-iteration cells.
// Throughput: one item per clock while the output register is free or being taken;
//   a flush item drains one pending pixel. A pixel's result leaves 2*width+2
//   accepted items after it, then goes through the output register.
// Reset (synchronous, active low) restores width 640, height 480, method 0 and
//   empties the pipeline; a width or height write empties it the same way.
module binary_thinning_pass (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bt_in_if.sink     i_in,
    bt_out_if.source  o_out,
    bt_cfg_if.sink    i_cfg
);

    logic [bt_pkg::WID_W-1:0]  r_width;
    logic [bt_pkg::HGT_W-1:0]  r_height;
    logic                      r_method;
    logic [bt_pkg::WCL_W-1:0]  w_w;
    logic [bt_pkg::HGT_W-1:0]  w_h;
    logic                      w_clear;

    logic [bt_pkg::HGT_W-1:0]  r_in_row, n_in_row;
    logic [bt_pkg::COL_W-1:0]  r_in_col, n_in_col;
    logic [bt_pkg::PEND_W-1:0] r_pending;
    logic                      r_any;

    logic         w_accept, w_flush_ok, w_step, w_pix, w_result, w_cleared;
    bt_pkg::t_ent w_raw;
    bt_pkg::t_ent w_mid;
    bt_pkg::t_res w_res_a, w_res_b;

    logic         r_out_valid;
    logic [7:0]   r_pixel_out;
    logic         r_cleared, r_last, r_changed;

    // Configuration: always ready; geometry writes restart the pipeline.
    assign i_cfg.ready = 1'b1;
    assign w_clear = i_cfg.valid && (i_cfg.index == bt_pkg::REG_WIDTH
                                     || i_cfg.index == bt_pkg::REG_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bt_pkg::WID_W'(640);
            r_height <= bt_pkg::HGT_W'(480);
            r_method <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                bt_pkg::REG_WIDTH:  r_width  <= i_cfg.data[bt_pkg::WID_W-1:0];
                bt_pkg::REG_HEIGHT: r_height <= i_cfg.data[bt_pkg::HGT_W-1:0];
                bt_pkg::REG_METHOD: r_method <= i_cfg.data[0];
                default:            ;
            endcase
        end
    end

    // Clamp geometry to what the line memories hold.
    assign w_w = (r_width < bt_pkg::WID_W'(3)) ? bt_pkg::WCL_W'(3)
               : (32'(r_width) > bt_pkg::MAX_WIDTH) ? bt_pkg::WCL_W'(bt_pkg::MAX_WIDTH)
               : bt_pkg::WCL_W'(r_width);
    assign w_h = (r_height < bt_pkg::HGT_W'(3)) ? bt_pkg::HGT_W'(3) : r_height;

    // Accept whenever the output register is free or being emptied.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_pix      = w_accept && (i_in.func == bt_pkg::FUNC_PIXEL);
    // A flush only moves the pipeline between frames with pixels inside.
    assign w_flush_ok = (r_pending != '0) && (r_in_row == '0) && (r_in_col == '0);
    assign w_step     = w_pix || (w_accept && i_in.func == bt_pkg::FUNC_FLUSH && w_flush_ok);

    // Binarize; a flush pushes an empty slot.
    assign w_raw.valid = w_pix;
    assign w_raw.raw   = w_pix && (i_in.pixel >= bt_pkg::FG_LEVEL);
    assign w_raw.s     = w_raw.raw;

    bt_cell u_cell_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (w_clear),
        .i_step   (w_step),
        .i_in     (w_raw),
        .i_width  (w_w),
        .i_height (w_h),
        .i_method (r_method),
        .i_second (1'b0),
        .o_res    (w_res_a)
    );

    // Hand the first sub-iteration's centre to the second as its newest slot.
    assign w_mid.valid = w_res_a.valid;
    assign w_mid.raw   = w_res_a.raw;
    assign w_mid.s     = w_res_a.s;

    bt_cell u_cell_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (w_clear),
        .i_step   (w_step),
        .i_in     (w_mid),
        .i_width  (w_w),
        .i_height (w_h),
        .i_method (r_method),
        .i_second (1'b1),
        .o_res    (w_res_b)
    );

    assign w_result  = w_step && w_res_b.valid;
    assign w_cleared = w_res_b.raw && !w_res_b.s;

    // Input raster position: tells when a frame is complete.
    always_comb begin
        n_in_col = r_in_col + 1'b1;
        n_in_row = r_in_row;
        if (r_in_col == bt_pkg::COL_W'(w_w - 1'b1)) begin
            n_in_col = '0;
            n_in_row = (r_in_row == w_h - 1'b1) ? '0 : r_in_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_pending <= '0;
            r_any     <= 1'b0;
        end else begin
            if (w_pix) begin
                r_in_row <= n_in_row;
                r_in_col <= n_in_col;
            end
            // count pixels inside; one leaves with each result
            case ({w_pix, w_result && r_pending != '0})
                2'b10:   r_pending <= r_pending + 1'b1;
                2'b01:   r_pending <= r_pending - 1'b1;
                default: ;
            endcase
            if (w_result) begin
                r_any <= w_res_b.last ? 1'b0 : (r_any | w_cleared);
            end
        end
    end

    // Output register: load on a result, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_result) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result) begin
            r_pixel_out <= w_res_b.s ? bt_pkg::PIX_ON : bt_pkg::PIX_OFF;
            r_cleared   <= w_cleared;
            r_last      <= w_res_b.last;
            r_changed   <= w_res_b.last && (r_any | w_cleared);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.pixel_out     = r_pixel_out;
    assign o_out.cleared       = r_cleared;
    assign o_out.last          = r_last;
    assign o_out.frame_changed = r_changed;

    a_changed_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_changed |-> r_last)
        else $error("frame_changed raised off the last pixel");
    a_cleared_is_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_cleared |-> r_pixel_out == bt_pkg::PIX_OFF)
        else $error("cleared pixel still foreground");
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear |=> r_pending == '0 && !r_any)
        else $error("geometry write left pixels pending");

endmodule

### hdl/bt_cell.sv
// One 3x3 thinning sub-iteration cell: line memory, window and table lookup.
module bt_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  logic                       i_step,
    input  bt_pkg::t_ent               i_in,
    input  logic [bt_pkg::WCL_W-1:0]   i_width,
    input  logic [bt_pkg::HGT_W-1:0]   i_height,
    input  logic                       i_method,
    input  logic                       i_second,
    output bt_pkg::t_res               o_res
);

    // Taps named by their distance back in the stream.
    bt_pkg::t_ent r_h1, r_h2, r_m1, r_w1, r_w2, r_m2, r_v1, r_v2;
    logic [5:0]   r_mem [0:bt_pkg::MEM_DEPTH-1];
    logic [bt_pkg::COL_W-1:0] r_ptr, n_ptr, r_fill, r_col, n_col;
    logic [bt_pkg::HGT_W-1:0] r_row, n_row;
    logic [bt_pkg::COL_W-1:0] w_wm1, w_wm2;
    logic [7:0]   w_code;
    logic         w_border;
    logic         w_keep;

    assign w_wm1 = bt_pkg::COL_W'(i_width - 1'b1);
    assign w_wm2 = bt_pkg::COL_W'(i_width - 2'd2);

    assign n_ptr = (r_ptr == w_wm2) ? '0 : r_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_mem[r_ptr[bt_pkg::ADDR_W-1:0]] <= {r_m1, i_in};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_h1 <= '0; r_h2 <= '0; r_m1 <= '0; r_w1 <= '0;
            r_w2 <= '0; r_m2 <= '0; r_v1 <= '0; r_v2 <= '0;
            r_ptr <= '0; r_fill <= '0;
        end else if (i_step) begin
            r_h1 <= i_in;
            r_h2 <= r_h1;
            r_w1 <= r_m1;
            r_w2 <= r_w1;
            r_v1 <= r_m2;
            r_v2 <= r_v1;
            // slots not yet written since the last clear read as empty
            if (r_fill == w_wm1) begin
                {r_m2, r_m1} <= r_mem[r_ptr[bt_pkg::ADDR_W-1:0]];
            end else begin
                r_m1 <= '0;
                r_m2 <= '0;
                r_fill <= r_fill + 1'b1;
            end
            r_ptr <= n_ptr;
        end
    end

    // Centre position, advanced per valid centre.
    always_comb begin
        n_col = r_col + 1'b1;
        n_row = r_row;
        if (r_col == w_wm1) begin
            n_col = '0;
            n_row = (r_row == i_height - 1'b1) ? '0 : r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_step && r_w1.valid) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    assign w_code   = {r_w2.s, r_h2.s, r_h1.s, i_in.s, r_m1.s, r_m2.s, r_v1.s, r_v2.s};
    assign w_border = (r_row == '0) || (r_col == '0) || (r_row == i_height - 1'b1)
                      || (r_col == w_wm1);
    assign w_keep   = bt_pkg::thin_keep(i_second, i_method, w_code);

    assign o_res.valid = r_w1.valid;
    assign o_res.raw   = r_w1.raw;
    assign o_res.s     = w_border ? r_w1.s : (r_w1.s & w_keep);
    assign o_res.last  = (r_row == i_height - 1'b1) && (r_col == w_wm1);

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_clear) |-> r_fill <= w_wm1)
        else $error("line fill count passed the row length");
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_clear) |-> r_ptr <= w_wm2)
        else $error("line pointer out of ring");

endmodule

### sim/binary_thinning_pass_tb.sv
// Self-checking testbench for binary_thinning_pass: directed and random frames.
module binary_thinning_pass_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_SPARE  = 2'd3;            // unused register index
    localparam int         RING_SLOTS = 2 * bt_pkg::MAX_WIDTH + 4;
    localparam int         CYCLE_CAP  = 2_000_000;
    localparam int         SETTLE     = 16;

    typedef struct {
        logic [7:0] pixel_out;
        logic       cleared;
        logic       last;
        logic       frame_changed;
    } t_thin_px;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bt_in_if  pix_ch ();
    bt_out_if res_ch ();
    bt_cfg_if cfg_ch ();

    binary_thinning_pass dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (pix_ch.sink),
        .o_out   (res_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mirror of the block's state: geometry, method, both line rings, counters.
    int          geo_w, geo_h;
    logic        use_gh;
    logic [1:0]  raw_ring [RING_SLOTS];     // {valid, pixel}
    logic [2:0]  mid_ring [RING_SLOTS];     // {valid, raw, stage-1 result}
    int          wr_ptr;
    int          in_row, in_col, a_row, a_col, b_row, b_col;
    int          in_flight;
    logic        saw_clear;

    t_thin_px    due_pixels[$];             // predicted results, oldest first
    int          n_errors = 0;
    int          n_items = 0;
    bit          steady = 1'b0;             // when set, neither side idles
    int          cycles = 0;

    function automatic int eff_w();
        return geo_w < 3 ? 3 : (geo_w > bt_pkg::MAX_WIDTH ? bt_pkg::MAX_WIDTH : geo_w);
    endfunction

    function automatic int eff_h();
        return geo_h < 3 ? 3 : geo_h;
    endfunction

    function automatic int ring_back(int back);
        int k;
        k = wr_ptr + RING_SLOTS - back;
        if (k >= RING_SLOTS) k -= RING_SLOTS;
        return k;
    endfunction

    // Neighbor code, up-left in bit 0 round to left in bit 7.
    function automatic logic [7:0] nbr_code(bit second, int w);
        int dr [8] = '{-1, -1, -1, 0, 1, 1, 1, 0};
        int dc [8] = '{-1, 0, 1, 1, 1, 0, -1, -1};
        logic [7:0] code;
        int k;
        code = '0;
        for (int b = 0; b < 8; b++) begin
            k = ring_back(w + 1 - dr[b] * w - dc[b]);
            code[b] = second ? mid_ring[k][0] : raw_ring[k][0];
        end
        return code;
    endfunction

    function automatic logic table_bit(bit second, logic [7:0] code);
        if (!use_gh) return second ? bt_pkg::TAB_ZS_B[code] : bt_pkg::TAB_ZS_A[code];
        return second ? bt_pkg::TAB_GH_B[code] : bt_pkg::TAB_GH_A[code];
    endfunction

    function automatic bit at_border(int r, int c, int w, int h);
        return r == 0 || c == 0 || r + 1 >= h || c + 1 >= w;
    endfunction

    task automatic step_pos(inout int r, inout int c, input int w, input int h);
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
    endtask

    task automatic empty_pipe();
        foreach (raw_ring[k]) raw_ring[k] = '0;
        foreach (mid_ring[k]) mid_ring[k] = '0;
        wr_ptr = 0;
        in_row = 0; in_col = 0; a_row = 0; a_col = 0; b_row = 0; b_col = 0;
        in_flight = 0;
        saw_clear = 1'b0;
    endtask

    // Advance the mirror by one accepted item; queue the pixel it releases.
    task automatic thin_step(input logic fl, input logic [7:0] pix);
        int w, h;
        logic v, vld, raw, s, fin, clr, lst, chg;
        logic [1:0] ca;
        logic [2:0] cb, ment;
        t_thin_px r;
        w = eff_w();
        h = eff_h();
        v = 1'b0;
        vld = 1'b0;
        ment = '0;
        if (fl == bt_pkg::FUNC_FLUSH) begin
            if (in_flight == 0 || in_row != 0 || in_col != 0) return;
        end else begin
            v = pix >= bt_pkg::FG_LEVEL;
            vld = 1'b1;
            in_flight++;
        end
        raw_ring[wr_ptr] = {vld, v};
        ca = raw_ring[ring_back(w + 1)];
        if (ca[1]) begin
            raw = ca[0];
            s = raw;
            if (!at_border(a_row, a_col, w, h)) s = raw & table_bit(0, nbr_code(0, w));
            ment = {1'b1, raw, s};
            step_pos(a_row, a_col, w, h);
        end
        mid_ring[wr_ptr] = ment;
        cb = mid_ring[ring_back(w + 1)];
        if (cb[2]) begin
            raw = cb[1];
            fin = cb[0];
            if (!at_border(b_row, b_col, w, h)) fin = fin & table_bit(1, nbr_code(1, w));
            clr = raw & ~fin;
            lst = (b_row + 1 == h) && (b_col + 1 == w);
            chg = saw_clear | clr;
            r.pixel_out = fin ? bt_pkg::PIX_ON : bt_pkg::PIX_OFF;
            r.cleared = clr;
            r.last = lst;
            r.frame_changed = lst ? chg : 1'b0;
            saw_clear = lst ? 1'b0 : chg;
            if (in_flight > 0) in_flight--;
            step_pos(b_row, b_col, w, h);
            due_pixels.push_back(r);
        end
        wr_ptr = (wr_ptr + 1 >= RING_SLOTS) ? 0 : wr_ptr + 1;
        if (fl != bt_pkg::FUNC_FLUSH) step_pos(in_row, in_col, w, h);
    endtask

    // Send one item; valid stays high after acceptance so the next item can follow.
    task automatic send_item(input logic fl, input logic [7:0] pix);
        if (!steady && $urandom_range(0, 99) < 30) begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.func  <= fl;
        pix_ch.pixel <= pix;
        do @(posedge i_clk); while (!pix_ch.ready);
        thin_step(fl, pix);
        n_items++;
    endtask

    // Hold input, wait for every predicted pixel, then write one register.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        pix_ch.valid <= 1'b0;
        while (due_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            bt_pkg::REG_WIDTH: begin
                geo_w = val & 16'h07FF;
                empty_pipe();
            end
            bt_pkg::REG_HEIGHT: begin
                geo_h = val;
                empty_pipe();
            end
            bt_pkg::REG_METHOD: use_gh = val[0];
            default: ;
        endcase
    endtask

    // Random content: each pixel is foreground with a chance of fg_pct percent, independently.
    function automatic logic [7:0] rand_pixel(int fg_pct);
        if ($urandom_range(0, 99) < fg_pct) return 8'($urandom_range(128, 255));
        return 8'($urandom_range(0, 127));
    endfunction

    task automatic send_frame(input int fg_pct);
        int n;
        n = eff_w() * eff_h();
        for (int k = 0; k < n; k++) send_item(bt_pkg::FUNC_PIXEL, rand_pixel(fg_pct));
    endtask

    task automatic drain(input int extra);
        repeat (2 * eff_w() + 2 + extra) send_item(bt_pkg::FUNC_FLUSH, 8'($urandom));
    endtask

    // Reset geometry: a few pixels, then a flush that mid-frame must be ignored.
    task automatic test_reset_state();
        repeat (5) send_item(bt_pkg::FUNC_PIXEL, 8'($urandom));
        send_item(bt_pkg::FUNC_FLUSH, 8'h00);
    endtask

    // Smallest frame, threshold edges, flush with nothing pending.
    task automatic test_smallest_frame();
        logic [7:0] edge_px [9] = '{8'd0, 8'd127, 8'd128, 8'd255, 8'd255,
                                    8'd255, 8'd128, 8'd127, 8'd0};
        write_reg(bt_pkg::REG_WIDTH, 16'd3);
        write_reg(bt_pkg::REG_HEIGHT, 16'd3);
        write_reg(bt_pkg::REG_METHOD, 16'd0);
        send_item(bt_pkg::FUNC_FLUSH, 8'hFF);
        foreach (edge_px[k]) send_item(bt_pkg::FUNC_PIXEL, edge_px[k]);
        drain(2);
    endtask

    // Full 5x5 block under each method, frames back to back before the drain.
    // Run with no idling on either side.
    task automatic test_methods_back_to_back();
        steady = 1'b1;
        write_reg(bt_pkg::REG_WIDTH, 16'd5);
        write_reg(bt_pkg::REG_HEIGHT, 16'd5);
        for (int m = 0; m < 2; m++) begin
            write_reg(bt_pkg::REG_METHOD, 16'(m));
            repeat (25) send_item(bt_pkg::FUNC_PIXEL, 8'd255);
            send_frame(70);
            drain(1);
        end
        steady = 1'b0;
    endtask

    // Out-of-range geometry, the widest line, the tallest frame, unused index.
    task automatic test_geometry_limits();
        write_reg(bt_pkg::REG_WIDTH, 16'd0);
        write_reg(bt_pkg::REG_HEIGHT, 16'd2);
        send_frame(60);
        drain(0);
        write_reg(bt_pkg::REG_WIDTH, 16'hFFFF);
        write_reg(bt_pkg::REG_HEIGHT, 16'd0);
        repeat (8) send_item(bt_pkg::FUNC_PIXEL, rand_pixel(60));
        write_reg(bt_pkg::REG_WIDTH, 16'd1024);
        write_reg(bt_pkg::REG_HEIGHT, 16'hFFFF);
        repeat (20) send_item(bt_pkg::FUNC_PIXEL, rand_pixel(50));
        send_item(bt_pkg::FUNC_FLUSH, 8'h00);
        write_reg(REG_SPARE, 16'hFFFF);
        write_reg(bt_pkg::REG_HEIGHT, 16'd3);
    endtask

    // Random geometry and content; mostly whole frames, some noise flushes.
    task automatic test_random_frames();
        int stop_at, sel;
        stop_at = n_items + 1250;
        while (n_items < stop_at) begin
            write_reg(bt_pkg::REG_WIDTH, 16'($urandom_range(3, 10)));
            write_reg(bt_pkg::REG_HEIGHT, 16'($urandom_range(3, 8)));
            write_reg(bt_pkg::REG_METHOD, 16'($urandom_range(0, 1)));
            steady = ($urandom_range(0, 5) == 0);
            repeat ($urandom_range(1, 3)) begin
                sel = $urandom_range(0, 9);
                if (sel == 0) begin
                    // broken frame: stray flushes mid-frame, then the rest
                    repeat (eff_w() + 1) send_item(bt_pkg::FUNC_PIXEL, rand_pixel(55));
                    repeat (3) send_item(bt_pkg::FUNC_FLUSH, 8'($urandom));
                    repeat (eff_w() * eff_h() - eff_w() - 1)
                        send_item(bt_pkg::FUNC_PIXEL, rand_pixel(55));
                end else begin
                    send_frame($urandom_range(30, 90));
                end
            end
            drain($urandom_range(0, 3));
        end
        steady = 1'b0;
    endtask

    // Result side: random backpressure, none while steady is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) res_ch.ready <= 1'b0;
        else res_ch.ready <= steady || ($urandom_range(0, 99) >= 30);
    end

    // Check each accepted result against the oldest predicted pixel.
    always @(posedge i_clk) begin
        t_thin_px e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (due_pixels.size() == 0) begin
                $error("result with nothing expected: pixel_out %0d", res_ch.pixel_out);
                n_errors++;
            end else begin
                e = due_pixels.pop_front();
                if (res_ch.pixel_out !== e.pixel_out) begin
                    $error("pixel_out expected %0d actual %0d", e.pixel_out, res_ch.pixel_out);
                    n_errors++;
                end
                if (res_ch.cleared !== e.cleared) begin
                    $error("cleared expected %0d actual %0d", e.cleared, res_ch.cleared);
                    n_errors++;
                end
                if (res_ch.last !== e.last) begin
                    $error("last expected %0d actual %0d", e.last, res_ch.last);
                    n_errors++;
                end
                if (res_ch.frame_changed !== e.frame_changed) begin
                    $error("frame_changed expected %0d actual %0d",
                           e.frame_changed, res_ch.frame_changed);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: give up on a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        pix_ch.valid = 1'b0;
        pix_ch.func  = bt_pkg::FUNC_PIXEL;
        pix_ch.pixel = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = bt_pkg::REG_WIDTH;
        cfg_ch.data  = '0;
        geo_w = 640;
        geo_h = 480;
        use_gh = 1'b0;
        empty_pipe();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_smallest_frame();
        test_methods_back_to_back();
        test_geometry_limits();
        test_random_frames();

        // drop input, let the last pixels out, then settle
        pix_ch.valid <= 1'b0;
        while (due_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (n_errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
